// ===== design/chm_pkg.sv =====
// chained hash map shared package: widths, request codes, sequencer states.
// Depends on nothing.
`default_nettype none
package chm_pkg;
   localparam int BUCKETS_DEF = 8192;
   localparam int NODES_DEF   = 1024;
   localparam int KEY_W = 31;
   localparam int VAL_W = 31;
   localparam int RV_W  = 32;

   typedef enum logic [1:0] {
      REQ_PUT = 2'd0,
      REQ_GET = 2'd1,
      REQ_REM = 2'd2,
      REQ_NOP = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD_RD,
      ST_HEAD_WT,
      ST_NODE_WT,
      ST_NODE_CMP,
      ST_FREE_RD,
      ST_FREE_WT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== design/chained_hash_map_top.sv =====
// Top level of the chained hash map: sequencer, bucket-head and node memories.
// Depends on chm_pkg and chm_ram.
`default_nettype none
// Key-value map with separate chaining. The bucket is the key modulo BUCKETS
// (low key bits when BUCKETS is a power of two). After reset the block sweeps
// the bucket-head memory to null, one entry per cycle, and accepts no request
// meanwhile. One request is worked at a time: each chain node visited costs
// one read of the node memories then a key compare, and a put that reuses a
// released node must first read that node's link. The node memory read port
// sets the pace. Results sit in an output register; the next request is taken
// once the result transfer completes. A put of a new key with no free node
// reports pool_full and stores nothing; a get of an absent key reads -1.
module chained_hash_map_top #(
   parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
   parameter int NODES   = chm_pkg::NODES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_type,
   input  wire logic [chm_pkg::KEY_W-1:0] req_key,
   input  wire logic [chm_pkg::VAL_W-1:0] req_new_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_found,
   output logic signed [chm_pkg::RV_W-1:0] rsp_read_value,
   output logic                          rsp_pool_full
);
   localparam int BW = $clog2(BUCKETS);
   localparam int NW = $clog2(NODES);
   localparam int LW = $clog2(NODES + 1); // link width, holds null
   localparam int CW = $clog2(NODES + 1); // step/fresh counter width
   localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

   chm_pkg::state_type state_ff, state_in;

   // request holding registers
   logic [1:0]                  rtype_ff, rtype_in;
   logic [chm_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [chm_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [BW-1:0]               bucket_ff, bucket_in;
   logic [LW-1:0]               cur_ff, cur_in;
   logic [LW-1:0]               prev_ff, prev_in;
   logic [LW-1:0]               head_ff, head_in;
   logic [CW-1:0]               steps_ff, steps_in;
   logic [CW-1:0]               fresh_ff, fresh_in;
   logic [LW-1:0]               free_ff, free_in;
   logic [BW-1:0]               clr_ff, clr_in;
   logic                        found_ff, found_in;
   logic [chm_pkg::RV_W-1:0]    rv_ff, rv_in;
   logic                        full_ff, full_in;

   // memory ports
   logic                        hd_we;
   logic [BW-1:0]               hd_wa, hd_ra;
   logic [LW-1:0]               hd_wd, hd_rd;
   logic                        k_we, v_we, l_we;
   logic [NW-1:0]               k_wa, v_wa, l_wa, n_ra;
   logic [chm_pkg::KEY_W-1:0]   k_wd, k_rd;
   logic [chm_pkg::VAL_W-1:0]   v_wd, v_rd;
   logic [LW-1:0]               l_wd, l_rd;

   // link write port shared between the sequencer and the pending free-link write
   logic          l_we_m;
   logic [NW-1:0] l_wa_m;
   logic [LW-1:0] l_wd_m;

   chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
      .clock(clock), .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_addr(hd_ra), .rd_data(hd_rd));
   chm_ram #(.WIDTH(chm_pkg::KEY_W), .DEPTH(NODES)) u_keys (
      .clock(clock), .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd),
      .rd_addr(n_ra), .rd_data(k_rd));
   chm_ram #(.WIDTH(chm_pkg::VAL_W), .DEPTH(NODES)) u_vals (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(n_ra), .rd_data(v_rd));
   chm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_links (
      .clock(clock), .wr_en(l_we_m), .wr_addr(l_wa_m), .wr_data(l_wd_m),
      .rd_addr(n_ra), .rd_data(l_rd));

   logic key_hit;
   logic walk_end;
   assign key_hit  = (k_rd == key_ff);
   assign walk_end = (cur_ff >= NULL_LINK) || (steps_ff >= CW'(NODES));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chm_pkg::ST_CLEAR: begin
            if (clr_ff == BW'(BUCKETS - 1)) state_in = chm_pkg::ST_IDLE;
         end
         chm_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == chm_pkg::REQ_NOP) state_in = chm_pkg::ST_DONE;
               else state_in = chm_pkg::ST_HEAD_RD;
            end
         end
         chm_pkg::ST_HEAD_RD: state_in = chm_pkg::ST_HEAD_WT;
         chm_pkg::ST_HEAD_WT: begin
            if (hd_rd >= NULL_LINK) state_in = chm_pkg::ST_NODE_CMP;
            else state_in = chm_pkg::ST_NODE_WT;
         end
         chm_pkg::ST_NODE_WT: state_in = chm_pkg::ST_NODE_CMP;
         chm_pkg::ST_NODE_CMP: begin
            if (walk_end) begin
               if (rtype_ff == chm_pkg::REQ_PUT && free_ff < NULL_LINK)
                  state_in = chm_pkg::ST_FREE_RD;
               else state_in = chm_pkg::ST_DONE;
            end else if (key_hit) state_in = chm_pkg::ST_DONE;
            else if (l_rd >= NULL_LINK) state_in = chm_pkg::ST_NODE_CMP;
            else state_in = chm_pkg::ST_NODE_WT;
         end
         chm_pkg::ST_FREE_RD: state_in = chm_pkg::ST_FREE_WT;
         chm_pkg::ST_FREE_WT: state_in = chm_pkg::ST_DONE;
         chm_pkg::ST_DONE: if (rsp_ready) state_in = chm_pkg::ST_IDLE;
         default: state_in = chm_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      rtype_in = rtype_ff; key_in = key_ff; val_in = val_ff;
      bucket_in = bucket_ff; cur_in = cur_ff; prev_in = prev_ff;
      head_in = head_ff; steps_in = steps_ff; fresh_in = fresh_ff;
      free_in = free_ff; clr_in = clr_ff; found_in = found_ff;
      rv_in = rv_ff; full_in = full_ff;
      hd_we = 1'b0; hd_wa = bucket_ff; hd_wd = NULL_LINK; hd_ra = bucket_ff;
      k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
      k_wa = cur_ff[NW-1:0]; v_wa = cur_ff[NW-1:0]; l_wa = cur_ff[NW-1:0];
      k_wd = key_ff; v_wd = val_ff; l_wd = head_ff;
      n_ra = cur_ff[NW-1:0];
      req_ready = 1'b0;
      unique case (state_ff)
         chm_pkg::ST_CLEAR: begin
            hd_we = 1'b1; hd_wa = clr_ff; hd_wd = NULL_LINK;
            clr_in = clr_ff + BW'(1);
         end
         chm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rtype_in  = req_type;
            key_in    = req_key;
            val_in    = req_new_value;
            bucket_in = BW'(req_key % BUCKETS);
            found_in = 1'b0; rv_in = '0; full_in = 1'b0;
         end
         chm_pkg::ST_HEAD_RD: begin
            hd_ra = bucket_ff;
         end
         chm_pkg::ST_HEAD_WT: begin
            head_in = hd_rd; cur_in = hd_rd; prev_in = NULL_LINK;
            steps_in = '0;
            n_ra = hd_rd[NW-1:0];
         end
         chm_pkg::ST_NODE_WT: begin
            n_ra = cur_ff[NW-1:0];
         end
         chm_pkg::ST_NODE_CMP: begin
            n_ra = l_rd[NW-1:0];
            if (walk_end) begin
               // absent key
               unique case (rtype_ff)
                  chm_pkg::REQ_PUT: begin
                     if (free_ff < NULL_LINK) begin
                        cur_in = free_ff;
                     end else if (fresh_ff < CW'(NODES)) begin
                        k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
                        k_wa = fresh_ff[NW-1:0]; v_wa = fresh_ff[NW-1:0];
                        l_wa = fresh_ff[NW-1:0]; l_wd = head_ff;
                        hd_we = 1'b1; hd_wd = LW'(fresh_ff);
                        fresh_in = fresh_ff + CW'(1);
                     end else full_in = 1'b1;
                  end
                  chm_pkg::REQ_GET: rv_in = '1;
                  default: ;
               endcase
            end else if (key_hit) begin
               found_in = 1'b1;
               unique case (rtype_ff)
                  chm_pkg::REQ_PUT: v_we = 1'b1;
                  chm_pkg::REQ_GET: rv_in = {1'b0, v_rd};
                  default: begin
                     // unlink and push on the free list
                     if (prev_ff < NULL_LINK) begin
                        l_we = 1'b1; l_wa = prev_ff[NW-1:0]; l_wd = l_rd;
                     end else begin
                        hd_we = 1'b1; hd_wd = l_rd;
                     end
                     free_in = cur_ff;
                  end
               endcase
            end else begin
               prev_in = cur_ff; cur_in = l_rd;
               steps_in = steps_ff + CW'(1);
            end
         end
         chm_pkg::ST_FREE_RD: begin
            n_ra = cur_ff[NW-1:0];
         end
         chm_pkg::ST_FREE_WT: begin
            // reuse released node; its old link is the new free head
            free_in = l_rd;
            k_we = 1'b1; v_we = 1'b1; l_we = 1'b1; l_wd = head_ff;
            hd_we = 1'b1; hd_wd = cur_ff;
         end
         chm_pkg::ST_DONE: ;
         default: ;
      endcase
      // the remove path writes the hit node's link after the unlink write;
      // the link port is free then only when prev is null, so do it in DONE
   end

   // pending free-link write for a remove: hit node links to old free head
   logic              fl_pend_ff, fl_pend_in;
   logic [NW-1:0]     fl_node_ff, fl_node_in;
   logic [LW-1:0]     fl_link_ff, fl_link_in;
   logic              fl_we;
   always_comb begin
      fl_pend_in = 1'b0;
      fl_node_in = cur_ff[NW-1:0];
      fl_link_in = free_ff;
      if (state_ff == chm_pkg::ST_NODE_CMP && !walk_end && key_hit
          && rtype_ff == chm_pkg::REQ_REM) fl_pend_in = 1'b1;
      fl_we = fl_pend_ff;
   end

   assign l_we_m = l_we | fl_we;
   assign l_wa_m = fl_we ? fl_node_ff : l_wa;
   assign l_wd_m = fl_we ? fl_link_ff : l_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chm_pkg::ST_CLEAR;
         clr_ff   <= '0;
         fresh_ff <= '0;
         free_ff  <= NULL_LINK;
         fl_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         fresh_ff <= fresh_in;
         free_ff  <= free_in;
         fl_pend_ff <= fl_pend_in;
      end
      rtype_ff <= rtype_in; key_ff <= key_in; val_ff <= val_in;
      bucket_ff <= bucket_in; cur_ff <= cur_in; prev_ff <= prev_in;
      head_ff <= head_in; steps_ff <= steps_in; found_ff <= found_in;
      rv_ff <= rv_in; full_ff <= full_in;
      fl_node_ff <= fl_node_in; fl_link_ff <= fl_link_in;
   end

   // outputs
   always_comb begin
      rsp_valid      = (state_ff == chm_pkg::ST_DONE);
      rsp_found      = found_ff;
      rsp_read_value = rv_ff;
      rsp_pool_full  = full_ff;
   end

   // --- assertions ---
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pool_full) |-> !rsp_found)
      else $error("pool_full with a found key");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_value != '0 |-> rtype_ff == chm_pkg::REQ_GET)
      else $error("read value on a non-get request");
   assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= CW'(NODES))
      else $error("fresh count past pool size");
endmodule
`default_nettype wire

// ===== design/chm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire
